// File: design/ubsd_pkg.sv
// Shared types, constants and decode functions for the Unicode byte-stream decoder.
`timescale 1ns / 1ps

package ubsd_pkg;

   localparam int ByteW     = 8;
   localparam int CpW       = 21;
   localparam int ModeW     = 4;
   localparam int EncW      = 3;
   localparam int CntW      = 3;
   localparam int MaxRes    = 4;
   localparam int FifoDepth = 8;
   localparam int FifoPtrW  = $clog2(FifoDepth);
   localparam int FifoCntW  = $clog2(FifoDepth + 1);

   // decode_mode register codes
   localparam logic [ModeW-1:0] ModeAscii    = 4'd0;
   localparam logic [ModeW-1:0] ModeUtf8     = 4'd1;
   localparam logic [ModeW-1:0] ModeU16Be    = 4'd2;
   localparam logic [ModeW-1:0] ModeU16Le    = 4'd3;
   localparam logic [ModeW-1:0] ModeU32Be    = 4'd4;
   localparam logic [ModeW-1:0] ModeU32Le    = 4'd5;
   localparam logic [ModeW-1:0] ModeDetect   = 4'd6;
   localparam logic [ModeW-1:0] ModeDetect16 = 4'd7;
   localparam logic [ModeW-1:0] ModeDetect32 = 4'd8;

   // active encoding codes
   localparam logic [EncW-1:0] EncAscii   = 3'd0;
   localparam logic [EncW-1:0] EncUtf8    = 3'd1;
   localparam logic [EncW-1:0] EncU16Be   = 3'd2;
   localparam logic [EncW-1:0] EncU16Le   = 3'd3;
   localparam logic [EncW-1:0] EncU32Be   = 3'd4;
   localparam logic [EncW-1:0] EncU32Le   = 3'd5;
   localparam logic [EncW-1:0] EncDiscard = 3'd7;

   localparam logic [31:0] CpLimit = 32'h0011_0000;

   typedef logic [3:0][ByteW-1:0] quad_type;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             string_end;
   } req_item_type;

   typedef struct packed {
      logic [CpW-1:0] code_point;
      logic           run_last;
   } rsp_item_type;

   typedef struct packed {
      logic [CntW-1:0]                num;
      rsp_item_type [MaxRes-1:0]      items;
   } batch_type;

   typedef struct packed {
      logic [EncW-1:0] enc;
      logic [CntW-1:0] skip;
   } mark_type;

   function automatic quad_type pad_quad(input quad_type q, input logic [CntW-1:0] n);
      quad_type r;
      r = q;
      for (int i = 0; i < 4; i++) begin
         if (CntW'(i) >= n) r[i] = '0;
      end
      return r;
   endfunction

   function automatic logic [CntW-1:0] bytes_needed(input logic [EncW-1:0] enc,
                                                    input quad_type q,
                                                    input logic [CntW-1:0] n);
      logic [ByteW-1:0] hi;
      hi = (enc == EncU16Be) ? q[0] : q[1];
      if (enc == EncUtf8) begin
         if (q[0] < 8'h80) return 3'd1;
         if (q[0] < 8'hE0) return 3'd2;
         if (q[0] < 8'hF0) return 3'd3;
         return 3'd4;
      end
      if (enc == EncU16Be || enc == EncU16Le) begin
         if (n < 3'd2) return 3'd2;
         return (hi >= 8'hD8 && hi <= 8'hDB) ? 3'd4 : 3'd2;
      end
      if (enc == EncU32Be || enc == EncU32Le) return 3'd4;
      return 3'd1;
   endfunction

   function automatic logic [31:0] utf16_value(input logic [7:0] hi0, input logic [7:0] lo0,
                                               input logic [7:0] hi1, input logic [7:0] lo1);
      logic [19:0] sur;
      sur = {hi0[1:0], lo0, hi1[1:0], lo1};
      if (hi0 <= 8'hD7 || hi0 >= 8'hE0) return {16'h0, hi0, lo0};
      if (hi0 <= 8'hDB && hi1 >= 8'hDC && hi1 <= 8'hDF) return {12'h0, sur} + 32'h0001_0000;
      return '0;
   endfunction

   function automatic logic [31:0] decode_char(input quad_type q, input logic [EncW-1:0] enc);
      unique case (enc)
         EncAscii: return {24'h0, q[0]};
         EncUtf8: begin
            if (q[0] < 8'h80) return {24'h0, q[0]};
            if (q[0] < 8'hE0) return {21'h0, q[0][4:0], q[1][5:0]};
            if (q[0] < 8'hF0) return {16'h0, q[0][3:0], q[1][5:0], q[2][5:0]};
            if (q[0] < 8'hF8) return {11'h0, q[0][2:0], q[1][5:0], q[2][5:0], q[3][5:0]};
            return '0;
         end
         EncU16Be: return utf16_value(q[0], q[1], q[2], q[3]);
         EncU16Le: return utf16_value(q[1], q[0], q[3], q[2]);
         EncU32Be: return {q[0], q[1], q[2], q[3]};
         EncU32Le: return {q[3], q[2], q[1], q[0]};
         default:  return '0;
      endcase
   endfunction

   function automatic logic cp_ok(input logic [31:0] cp);
      return (cp != '0) && (cp < CpLimit);
   endfunction

   // byte-order mark match on the zero-padded head bytes
   function automatic mark_type detect_mark(input quad_type q, input logic prefer16);
      mark_type m;
      m.enc  = EncAscii;
      m.skip = 3'd0;
      if (q[0] == 8'hEF && q[1] == 8'hBB && q[2] == 8'hBF) begin
         m.enc  = EncUtf8;
         m.skip = 3'd3;
      end else if (q[0] == 8'hFE && q[1] == 8'hFF) begin
         m.enc  = EncU16Be;
         m.skip = 3'd2;
      end else if (q[0] == 8'hFF && q[1] == 8'hFE) begin
         if (q[2] == 8'h00 && q[3] == 8'h00 && !prefer16) begin
            m.enc  = EncU32Le;
            m.skip = 3'd4;
         end else begin
            m.enc  = EncU16Le;
            m.skip = 3'd2;
         end
      end else if (q[0] == 8'h00 && q[1] == 8'h00 && q[2] == 8'hFE && q[3] == 8'hFF) begin
         m.enc  = EncU32Be;
         m.skip = 3'd4;
      end
      return m;
   endfunction

endpackage

// File: design/ubsd_decoder.sv
// Decode state and the single-pass byte step: mark detection, character gathering, results.
`timescale 1ns / 1ps

module ubsd_decoder
   import ubsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  req_item_type        item,
   input  logic [ModeW-1:0]    mode,
   output batch_type           batch
);

   logic [EncW-1:0]          enc_ff, enc_in;
   logic                     done_ff, done_in;
   quad_type                 buf_ff, buf_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;

   logic [EncW-1:0]          enc_s;
   logic                     done_s;
   logic [CntW-1:0]          base_cnt;
   quad_type                 q_new;
   quad_type                 q_pad;
   logic [CntW-1:0]          n_new;
   mark_type                 mark;
   quad_type                 rest;
   logic [CntW-1:0]          rn;
   logic                     resolve;
   logic                     chk_en;
   logic [EncW-1:0]          chk_enc;
   quad_type                 chk_q;
   logic [CntW-1:0]          chk_n;
   logic [CntW-1:0]          need;
   logic                     chk_done;
   logic [31:0]              chk_cp;
   logic [MaxRes-1:0]        res_v;
   logic [MaxRes-1:0][CpW-1:0] res_cp;
   logic [CntW-1:0]          pos;

   always_comb begin
      enc_s  = enc_ff;
      done_s = done_ff;
      // mode is sampled on the first byte of each string
      if (!done_ff && cnt_ff == '0) begin
         if (mode <= ModeU32Le) begin
            enc_s  = mode[EncW-1:0];
            done_s = 1'b1;
         end else if (mode <= ModeDetect32) begin
            enc_s = (mode == ModeDetect16) ? EncUtf8 : EncAscii;
         end else begin
            enc_s  = EncDiscard;
            done_s = 1'b1;
         end
      end

      base_cnt = (cnt_ff > 3'd3) ? '0 : cnt_ff;
      q_new = buf_ff;
      q_new[base_cnt[1:0]] = item.data_byte;
      n_new = base_cnt + 3'd1;
      q_pad = pad_quad(q_new, n_new);

      // during detection enc holds the prefer-UTF-16 flag
      mark = detect_mark(q_pad, enc_s == EncUtf8);
      rest = q_pad >> {mark.skip, 3'b000};
      rn   = (mark.skip >= n_new) ? '0 : n_new - mark.skip;
      resolve = !done_s && (n_new == 3'd4 || item.string_end);

      chk_en   = done_s || (resolve && mark.enc != EncAscii && rn != '0);
      chk_enc  = done_s ? enc_s : mark.enc;
      chk_q    = done_s ? q_new : rest;
      chk_n    = done_s ? n_new : rn;
      need     = bytes_needed(chk_enc, chk_q, chk_n);
      chk_done = chk_en && (chk_n >= need || item.string_end);
      chk_cp   = decode_char(pad_quad(chk_q, chk_n), chk_enc);

      for (int i = 0; i < MaxRes; i++) begin
         res_cp[i] = {{(CpW-ByteW){1'b0}}, q_pad[i]};
         res_v[i]  = resolve && mark.enc == EncAscii && CntW'(i) < n_new && q_pad[i] != '0;
      end
      if (chk_done) begin
         res_v[0]  = cp_ok(chk_cp);
         res_cp[0] = chk_cp[CpW-1:0];
      end

      enc_in  = resolve ? mark.enc : enc_s;
      done_in = done_s || resolve;
      buf_in  = (!done_s && resolve) ? rest : q_new;
      if (chk_done) begin
         cnt_in = '0;
      end else if (resolve) begin
         cnt_in = (mark.enc == EncAscii) ? '0 : rn;
      end else begin
         cnt_in = n_new;
      end
      if (item.string_end) begin
         enc_in  = EncAscii;
         done_in = 1'b0;
         cnt_in  = '0;
      end
   end

   // pack valid results in order and tag the last one
   always_comb begin
      batch = '0;
      pos   = '0;
      for (int i = 0; i < MaxRes; i++) begin
         if (res_v[i]) begin
            batch.items[pos[1:0]] = '{code_point: res_cp[i], run_last: 1'b0};
            pos = pos + 3'd1;
         end
      end
      if (pos != '0) batch.items[2'(pos - 3'd1)].run_last = 1'b1;
      batch.num = fire ? pos : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_ff  <= EncAscii;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (fire) begin
         enc_ff  <= enc_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) buf_ff <= buf_in;
   end

endmodule

// File: design/ubsd_result_fifo.sv
// Result queue: takes up to four results per cycle, gives one per transfer.
`timescale 1ns / 1ps

module ubsd_result_fifo
   import ubsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  batch_type      wr_batch,
   output logic           room,
   output logic           rd_valid,
   input  logic           rd_stall,
   output rsp_item_type   rd_item
);

   rsp_item_type          mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   count_ff, count_in;
   logic                  pop;

   assign rd_valid  = count_ff != '0;
   assign rd_item   = mem_ff[rd_ptr_ff];
   assign pop       = rd_valid && !rd_stall;
   assign room      = count_ff <= FifoCntW'(FifoDepth - MaxRes);
   assign wr_ptr_in = wr_ptr_ff + FifoPtrW'(wr_batch.num);
   assign rd_ptr_in = rd_ptr_ff + FifoPtrW'(pop);
   assign count_in  = count_ff + FifoCntW'(wr_batch.num) - FifoCntW'(pop);

   always_ff @(posedge clock) begin
      for (int e = 0; e < FifoDepth; e++) begin
         if (FifoPtrW'(FifoPtrW'(e) - wr_ptr_ff) < wr_batch.num) begin
            mem_ff[e] <= wr_batch.items[2'(FifoPtrW'(e) - wr_ptr_ff)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FifoCntW'(FifoDepth))
      else $error("result queue count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (wr_batch.num != '0) |-> (count_ff <= FifoCntW'(FifoDepth - MaxRes)))
      else $error("results written without room for a full batch");

   a_batch_size: assert property (@(posedge clock) disable iff (reset)
      wr_batch.num <= CntW'(MaxRes))
      else $error("batch larger than four results");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FifoCntW'(FifoDepth)) == (rd_ptr_ff == wr_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// File: design/unicode_bom_stream_decoder_core.sv
// Top level of the Unicode byte-stream decoder with byte-order-mark detection.
// A transferred byte is registered, then decoded once the queue has room. Throughput: one
// byte per cycle while results average at most one per byte; a byte that ends detection with
// no mark can yield four results, drained one per unstalled rsp cycle from an 8-entry queue, and
// req_stall rises while a byte waits in the input register and fewer than four slots are free.
// Reset (synchronous): decode state back to string start, queue empty, decode_mode to ASCII.
`timescale 1ns / 1ps

module unicode_bom_stream_decoder_core
   import ubsd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_item_type       req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_item_type       rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ModeW-1:0]   csr_data
);

   logic [ModeW-1:0]  mode_ff;
   logic              in_vld_ff, in_vld_in;
   req_item_type      in_item_ff;
   logic              room;
   logic              fire;
   logic              req_take;
   batch_type         batch;

   assign csr_ready = 1'b1;
   assign fire      = in_vld_ff && room;
   assign req_stall = in_vld_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeAscii;
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) mode_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_item_ff <= req_item;
   end

   ubsd_decoder u_decoder (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .mode  (mode_ff),
      .batch (batch)
   );

   ubsd_result_fifo u_result_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_batch (batch),
      .room     (room),
      .rd_valid (rsp_valid),
      .rd_stall (rsp_stall),
      .rd_item  (rsp_item)
   );

endmodule
